@@ hdl/imu_complementary_filter_top_assert.svh @@
// Assertion macros for the complementary filter block.
`ifndef IMU_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH
`define IMU_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH
// Assert that a condition always implies a consequence in the same cycle.
`define IMU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Assert that a condition implies a consequence in the following cycle.
`define IMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hdl/icf_pkg.sv @@
// Shared types and constants for the complementary filter block.
package icf_pkg;
  localparam int AngW = 24;
  localparam int CordW = 28;
  localparam int ZW = 26;
  localparam logic signed [AngW-1:0] AngMax = 24'sh7FFFFF;
  localparam logic signed [AngW-1:0] AngMin = -24'sh800000;

  typedef enum logic [1:0] {
    REG_GYRO_GAIN = 2'd0,
    REG_BLEND_ALPHA = 2'd1,
    REG_MAG_LOW = 2'd2,
    REG_MAG_HIGH = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    AXIS_PITCH = 2'd0,
    AXIS_ROLL = 2'd1,
    AXIS_YAW = 2'd2
  } axis_t;

  typedef struct packed {
    logic  load;
    logic  gyro;
    logic  cordic_init;
    logic  cordic_iter;
    logic  blend;
    logic  blend_wr;
    axis_t axis;
    logic [4:0] iter;
  } cmd_t;

  typedef struct packed {
    logic correct;
  } status_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        5'd0: r = 26'sd2949120;  5'd1: r = 26'sd1740967;
        5'd2: r = 26'sd919879;   5'd3: r = 26'sd466945;
        5'd4: r = 26'sd234379;   5'd5: r = 26'sd117304;
        5'd6: r = 26'sd58666;    5'd7: r = 26'sd29335;
        5'd8: r = 26'sd14668;    5'd9: r = 26'sd7334;
        5'd10: r = 26'sd3667;    5'd11: r = 26'sd1833;
        5'd12: r = 26'sd917;     5'd13: r = 26'sd458;
        5'd14: r = 26'sd229;     5'd15: r = 26'sd115;
        5'd16: r = 26'sd57;      5'd17: r = 26'sd29;
        5'd18: r = 26'sd14;      5'd19: r = 26'sd7;
        5'd20: r = 26'sd4;       5'd21: r = 26'sd2;
        5'd22: r = 26'sd1;       default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [AngW-1:0] sat24(input logic signed [47:0] v);
    begin
      if (v > 48'sd8388607) return AngMax;
      if (v < -48'sd8388608) return AngMin;
      return v[AngW-1:0];
    end
  endfunction
endpackage

@@ hdl/icf_datapath.sv @@
// Datapath: sample registers, gyro integration, shared CORDIC and blend unit.
module icf_datapath (
  input  logic clk,
  input  logic rst,
  input  icf_pkg::cmd_t cmd,
  output icf_pkg::status_t status,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  input  logic [15:0] gyro_gain,
  input  logic [15:0] blend_alpha,
  input  logic [16:0] magnitude_low,
  input  logic [16:0] magnitude_high,
  output logic signed [23:0] pitch_est,
  output logic signed [23:0] roll_est,
  output logic signed [23:0] yaw_est
);
  logic signed [15:0] ax, ay, az, gx, gy, gz;
  logic signed [icf_pkg::CordW-1:0] cx, cy;
  logic signed [icf_pkg::ZW-1:0] cz;
  logic signed [23:0] acc_ang;
  logic signed [47:0] prod_a, prod_b;
  logic [17:0] mag;
  logic signed [15:0] num, den;
  logic signed [23:0] est_sel;
  logic signed [icf_pkg::CordW-1:0] xs, ys;
  logic signed [icf_pkg::ZW-1:0] zr;
  logic signed [icf_pkg::ZW-1:0] tbl;
  logic signed [32:0] gp_x, gp_y, gp_z;
  logic signed [47:0] bsum;

  always_comb begin
    mag = 18'(ax[15] ? -17'(ax) : 17'(ax)) + 18'(ay[15] ? -17'(ay) : 17'(ay))
        + 18'(az[15] ? -17'(az) : 17'(az));
    status.correct = (mag > 18'(magnitude_low)) && (mag < 18'(magnitude_high));
    case (cmd.axis)
      icf_pkg::AXIS_PITCH: begin num = ay; den = az; est_sel = pitch_est; end
      icf_pkg::AXIS_ROLL:  begin num = ax; den = az; est_sel = roll_est; end
      default:             begin num = ax; den = ay; est_sel = yaw_est; end
    endcase
    xs = cx >>> cmd.iter;
    ys = cy >>> cmd.iter;
    tbl = icf_pkg::atan_entry(cmd.iter);
    zr = (cz + icf_pkg::ZW'(128)) >>> 8;
    // Both operands zero gives a zero angle.
    acc_ang = (num == 0 && den == 0) ? '0 : 24'(zr);
    gp_x = gx * $signed({1'b0, gyro_gain});
    gp_y = gy * $signed({1'b0, gyro_gain});
    gp_z = gz * $signed({1'b0, gyro_gain});
    bsum = prod_a + prod_b + 48'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_est <= '0;
      roll_est <= '0;
      yaw_est <= '0;
    end else begin
      if (cmd.gyro) begin
        pitch_est <= icf_pkg::sat24(48'(pitch_est) + 48'((48'(gp_x) + 48'sd8388608) >>> 24));
        roll_est <= icf_pkg::sat24(48'(roll_est) - 48'((48'(gp_y) + 48'sd8388608) >>> 24));
        yaw_est <= icf_pkg::sat24(48'(yaw_est) + 48'((48'(gp_z) + 48'sd8388608) >>> 24));
      end
      if (cmd.blend_wr) begin
        unique case (cmd.axis)
          icf_pkg::AXIS_PITCH: pitch_est <= icf_pkg::sat24(bsum >>> 16);
          icf_pkg::AXIS_ROLL:  roll_est <= icf_pkg::sat24(bsum >>> 16);
          default:             yaw_est <= icf_pkg::sat24(bsum >>> 16);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax <= accel_x; ay <= accel_y; az <= accel_z;
      gx <= gyro_x; gy <= gyro_y; gz <= gyro_z;
    end
    if (cmd.cordic_init) begin
      if (den < 0) begin
        if (num >= 0) begin
          cx <= icf_pkg::CordW'(num) <<< 8;
          cy <= -(icf_pkg::CordW'(den) <<< 8);
          cz <= 26'sd5898240;
        end else begin
          cx <= -(icf_pkg::CordW'(num) <<< 8);
          cy <= icf_pkg::CordW'(den) <<< 8;
          cz <= -26'sd5898240;
        end
      end else begin
        cx <= icf_pkg::CordW'(den) <<< 8;
        cy <= icf_pkg::CordW'(num) <<< 8;
        cz <= '0;
      end
    end else if (cmd.cordic_iter) begin
      if (cy > 0) begin
        cx <= cx + ys; cy <= cy - xs; cz <= cz + tbl;
      end else begin
        cx <= cx - ys; cy <= cy + xs; cz <= cz - tbl;
      end
    end
    if (cmd.blend) begin
      prod_a <= $signed({32'b0, blend_alpha}) * 48'(est_sel);
      prod_b <= $signed(48'(17'h10000 - 17'(blend_alpha))) * 48'(acc_ang);
    end
  end
endmodule

@@ hdl/icf_ctrl.sv @@
// Controller: sequences gyro update and, when the correction applies, three CORDIC runs and blends per item.
`include "imu_complementary_filter_top_assert.svh"
module icf_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic applied,
  input  icf_pkg::status_t status,
  output icf_pkg::cmd_t cmd
);
  localparam int Steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  typedef enum logic [2:0] {S_IDLE, S_GYRO, S_INIT, S_ITER, S_MUL, S_WR, S_OUT} state_t;
  state_t state;
  logic [4:0] iter;
  icf_pkg::axis_t axis;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.axis = axis;
    cmd.iter = iter;
    cmd.load = in_valid && in_ready;
    cmd.gyro = (state == S_GYRO);
    cmd.cordic_init = (state == S_INIT);
    cmd.cordic_iter = (state == S_ITER);
    cmd.blend = (state == S_MUL);
    cmd.blend_wr = (state == S_WR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter <= '0;
      axis <= icf_pkg::AXIS_PITCH;
      applied <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_GYRO;
        S_GYRO: begin
          axis <= icf_pkg::AXIS_PITCH;
          applied <= status.correct;
          state <= status.correct ? S_INIT : S_OUT;
        end
        S_INIT: begin iter <= '0; state <= S_ITER; end
        S_ITER: begin
          iter <= iter + 5'd1;
          if (iter == 5'(Steps - 1)) state <= S_MUL;
        end
        S_MUL: state <= S_WR;
        S_WR: begin
          if (axis == icf_pkg::AXIS_YAW) state <= S_OUT;
          else begin
            axis <= (axis == icf_pkg::AXIS_PITCH) ? icf_pkg::AXIS_ROLL : icf_pkg::AXIS_YAW;
            state <= S_INIT;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `IMU_ASSERT_IMPL(a_ready_out_excl, in_ready, !out_valid, "ready while result pending")
  `IMU_ASSERT_NEXT(a_load_to_gyro, in_valid && in_ready, cmd.gyro, "no gyro step after load")
  `IMU_ASSERT_IMPL(a_iter_bound, cmd.cordic_iter, iter < 5'(Steps), "iteration overrun")
endmodule

@@ hdl/imu_complementary_filter_top.sv @@
// Top level of the IMU complementary filter attitude estimator.
// One item (three accel and three gyro samples) is taken at a time. With no
// accelerometer correction the result follows the gyro step directly; with a
// correction the single shared CORDIC unit is run once per angle (pitch, roll,
// yaw), each run of CORDIC_STEPS iterations (at most 24) followed by a blend.
// The result is held until taken; the next item is accepted after.
// Configuration writes must happen while the block is idle.
module imu_complementary_filter_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [23:0] pitch_angle,
  output logic signed [23:0] roll_angle,
  output logic signed [23:0] yaw_angle,
  output logic accel_applied,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [16:0] cfg_data
);
  logic [15:0] gyro_gain, blend_alpha;
  logic [16:0] magnitude_low, magnitude_high;
  icf_pkg::cmd_t cmd;
  icf_pkg::status_t status;

  // Hold configuration registers; writes land at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_gain <= 16'd2621;
      blend_alpha <= 16'd64225;
      magnitude_low <= 17'd8192;
      magnitude_high <= 17'd32768;
    end else if (cfg_we) begin
      unique case (icf_pkg::reg_index_t'(cfg_index))
        icf_pkg::REG_GYRO_GAIN:   gyro_gain <= cfg_data[15:0];
        icf_pkg::REG_BLEND_ALPHA: blend_alpha <= cfg_data[15:0];
        icf_pkg::REG_MAG_LOW:     magnitude_low <= cfg_data;
        default:                  magnitude_high <= cfg_data;
      endcase
    end
  end

  icf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .applied(accel_applied), .status, .cmd
  );

  icf_datapath u_dp (
    .clk, .rst, .cmd, .status,
    .accel_x, .accel_y, .accel_z, .gyro_x, .gyro_y, .gyro_z,
    .gyro_gain, .blend_alpha, .magnitude_low, .magnitude_high,
    .pitch_est(pitch_angle), .roll_est(roll_angle), .yaw_est(yaw_angle)
  );
endmodule
